FILE: hw/rtl/gbts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbts_pkg
// Shared types and constants of the gap buffer text store.
// ----------------------------------------------------------------------------
package gbts_pkg;

	localparam int CAPACITY = 4096;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int FIELD_W  = 13;

	localparam logic [FIELD_W-1:0] CAP_LEN = FIELD_W'(CAPACITY);

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_READ   = 2'd2;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]         action;
		logic [FIELD_W-1:0] position;
		logic [7:0]         char_in;
		logic [FIELD_W-1:0] amount;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [7:0]         char_out;
		logic [FIELD_W-1:0] current_length;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       step;
		logic       rd_issue;
		logic       apply_ins;
		logic       apply_rem;
		logic       emit;
		logic       emit_char;
		logic [1:0] emit_status;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] action;
		logic       pos_gt_len;
		logic       pos_ge_len;
		logic       len_full;
		logic       gap_at_pos;
	} sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/gbts_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gbts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/gbts_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbts_dp
// Datapath: gap pointers, text length, command word latch, byte store and
// the result register.
// ----------------------------------------------------------------------------
module gbts_dp
	import gbts_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire req_t req,
	input  wire ctl_t ctl,
	output sts_t      sts,
	output logic      done,
	output rsp_t      rsp
);

	logic [1:0]         action_q;
	logic [FIELD_W-1:0] pos_q;
	logic [7:0]         char_q;
	logic [FIELD_W-1:0] amount_q;

	logic [FIELD_W-1:0] gs_q;
	logic [FIELD_W-1:0] ge_q;
	logic [FIELD_W-1:0] len_q;

	logic               wr_pend_s1;
	logic [ADDR_W-1:0]  wr_addr_s1;

	logic               done_q;
	rsp_t               rsp_q;

	logic               move_left;
	logic [FIELD_W-1:0] src;
	logic [FIELD_W-1:0] dst;
	logic [FIELD_W-1:0] phys;
	logic [FIELD_W-1:0] room;
	logic [FIELD_W-1:0] run;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [7:0]         ram_wdata;
	logic               ram_re;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [7:0]         ram_rdata;

	always_comb begin
		move_left = gs_q > pos_q;
		src       = move_left ? gs_q - 1'b1 : ge_q;
		dst       = move_left ? ge_q - 1'b1 : gs_q;
		phys      = (pos_q < gs_q) ? pos_q : ge_q + (pos_q - gs_q);
		room      = len_q - pos_q;
		run       = (amount_q > room) ? room : amount_q;

		sts.action     = action_q;
		sts.pos_gt_len = pos_q > len_q;
		sts.pos_ge_len = pos_q >= len_q;
		sts.len_full   = len_q == CAP_LEN;
		sts.gap_at_pos = gs_q == pos_q;

		// The controller never applies an insert while a copy write is pending.
		ram_we    = ctl.apply_ins | wr_pend_s1;
		ram_waddr = ctl.apply_ins ? gs_q[ADDR_W-1:0] : wr_addr_s1;
		ram_wdata = ctl.apply_ins ? char_q : ram_rdata;
		ram_re    = ctl.step | ctl.rd_issue;
		ram_raddr = ctl.rd_issue ? phys[ADDR_W-1:0] : src[ADDR_W-1:0];
	end

	gbts_ram #(
		.WIDTH(8),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			action_q <= req.action;
			pos_q    <= req.position;
			char_q   <= req.char_in;
			amount_q <= req.amount;
		end
		if (ctl.step) begin
			wr_addr_s1 <= dst[ADDR_W-1:0];
		end
		if (ctl.emit) begin
			rsp_q.status         <= ctl.emit_status;
			rsp_q.char_out       <= ctl.emit_char ? ram_rdata : 8'd0;
			rsp_q.current_length <= len_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gs_q       <= '0;
			ge_q       <= CAP_LEN;
			len_q      <= '0;
			wr_pend_s1 <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			wr_pend_s1 <= ctl.step;
			done_q     <= ctl.emit;
			if (ctl.step) begin
				if (move_left) begin
					gs_q <= gs_q - 1'b1;
					ge_q <= ge_q - 1'b1;
				end else begin
					gs_q <= gs_q + 1'b1;
					ge_q <= ge_q + 1'b1;
				end
			end else if (ctl.apply_ins) begin
				gs_q  <= gs_q + 1'b1;
				len_q <= len_q + 1'b1;
			end else if (ctl.apply_rem) begin
				ge_q  <= ge_q + run;
				len_q <= len_q - run;
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
`default_nettype wire

FILE: hw/rtl/gbts_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbts_ctrl
// Controller: checks each command word; for an insert or remove walks the gap
// to the edit point one byte per cycle and applies the edit; issues the result.
// ----------------------------------------------------------------------------
module gbts_ctrl
	import gbts_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire sts_t sts,
	output ctl_t      ctl,
	output logic      busy
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_MOVE,
		S_APPLY,
		S_RESP,
		S_RDWAIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = S_EVAL;
				end
			end
			S_EVAL: begin
				unique case (sts.action)
					ACT_INSERT: begin
						if (sts.pos_gt_len) begin
							ctl.emit        = 1'b1;
							ctl.emit_status = ST_RANGE;
							state_d         = S_IDLE;
						end else if (sts.len_full) begin
							ctl.emit        = 1'b1;
							ctl.emit_status = ST_FULL;
							state_d         = S_IDLE;
						end else begin
							state_d = S_MOVE;
						end
					end
					ACT_REMOVE: begin
						if (sts.pos_ge_len) begin
							ctl.emit        = 1'b1;
							ctl.emit_status = ST_RANGE;
							state_d         = S_IDLE;
						end else begin
							state_d = S_MOVE;
						end
					end
					ACT_READ: begin
						if (sts.pos_ge_len) begin
							ctl.emit        = 1'b1;
							ctl.emit_status = ST_RANGE;
							state_d         = S_IDLE;
						end else begin
							ctl.rd_issue = 1'b1;
							state_d      = S_RDWAIT;
						end
					end
					default: begin
						ctl.emit        = 1'b1;
						ctl.emit_status = ST_RANGE;
						state_d         = S_IDLE;
					end
				endcase
			end
			S_MOVE: begin
				// The cycle that finds the gap in place lets the last copy write land.
				if (!sts.gap_at_pos) begin
					ctl.step = 1'b1;
				end else begin
					state_d = S_APPLY;
				end
			end
			S_APPLY: begin
				ctl.apply_ins = sts.action == ACT_INSERT;
				ctl.apply_rem = sts.action != ACT_INSERT;
				state_d       = S_RESP;
			end
			S_RESP: begin
				ctl.emit        = 1'b1;
				ctl.emit_status = ST_DONE;
				state_d         = S_IDLE;
			end
			S_RDWAIT: begin
				ctl.emit        = 1'b1;
				ctl.emit_char   = 1'b1;
				ctl.emit_status = ST_DONE;
				state_d         = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= state_d != S_IDLE;
		end
	end

	assign busy = busy_q;

endmodule
`default_nettype wire

FILE: hw/rtl/gap_buffer_text_store_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gap_buffer_text_store_top
// Fixed-capacity gap buffer holding up to CAPACITY bytes of editable text.
// ----------------------------------------------------------------------------
// A command word on req is taken at a rising edge with start high and busy
// low: insert a byte, remove a run of bytes, or read a byte at a position.
// Each command yields exactly one result word on rsp, valid for the single
// cycle in which done is high; the receiver cannot hold it off, so it must
// capture it in that cycle. busy drops in the cycle done rises, so the next
// command may be issued while the result is shown.
// A rejected command is answered after its check; a read issues its store
// read first; an insert or remove walks the gap to its position, then edits.
// The gap moves one byte per cycle through the byte store's single read and
// single write port; an edit where the last one left the gap moves nothing.
// Reset clears the text to empty with the gap spanning the whole store; no
// clearing pass is needed, since only written bytes are ever read.
// ----------------------------------------------------------------------------
module gap_buffer_text_store_top
	import gbts_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t req,
	output logic      busy,
	output logic      done,
	output rsp_t      rsp
);

	ctl_t ctl;
	sts_t sts;

	gbts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	gbts_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ctl    (ctl),
		.sts    (sts),
		.done   (done),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gap buffer text store.
// ----------------------------------------------------------------------------
// A local copy of the buffer (store, gap bounds and text length) is updated for
// every accepted command and predicts the result word. A checker compares each
// word strobed by done with the oldest prediction. The run covers directed
// corner cases, a fill to capacity with full and range rejects, and random
// edit sequences clustered around the current edit point. These are run
// without idling, with a mostly idle sender, and with a lightly idle sender.
// ----------------------------------------------------------------------------
module tb_top;
	import gbts_pkg::*;

	localparam logic [1:0] ACT_UNKNOWN = 2'd3;
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int TAIL_CYCLES = 8;
	localparam int MAX_MAX = 8191;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	gap_buffer_text_store_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	always #2 clk = ~clk;

	// Predicted buffer contents.
	logic [7:0] text_mem [CAPACITY];
	int gap_lo = 0;
	int gap_hi = CAPACITY;
	int text_len = 0;

	rsp_t pending_rsps [$];
	int error_count = 0;
	int word_count = 0;
	int sender_idle_pct = 0;
	int unsigned cycle_count = 0;

	function automatic void slide_gap(int p);
		while (gap_lo > p && gap_hi > 0) begin
			gap_lo--;
			gap_hi--;
			text_mem[gap_hi] = text_mem[gap_lo];
		end
		while (gap_lo < p && gap_hi < CAPACITY) begin
			text_mem[gap_lo] = text_mem[gap_hi];
			gap_lo++;
			gap_hi++;
		end
	endfunction

	function automatic rsp_t apply_command(req_t w);
		rsp_t r;
		int p;
		int n;
		int phys;
		r = '0;
		p = int'(w.position);
		n = int'(w.amount);
		r.status = ST_DONE;
		case (w.action)
			ACT_INSERT: begin
				if (p > text_len) begin
					r.status = ST_RANGE;
				end else if (text_len >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					slide_gap(p);
					if (gap_lo < gap_hi && gap_lo < CAPACITY) begin
						text_mem[gap_lo] = w.char_in;
						gap_lo++;
						text_len++;
					end else begin
						r.status = ST_FULL;
					end
				end
			end
			ACT_REMOVE: begin
				if (p >= text_len) begin
					r.status = ST_RANGE;
				end else begin
					if (n > text_len - p)
						n = text_len - p;
					slide_gap(p);
					gap_hi += n;
					if (gap_hi > CAPACITY)
						gap_hi = CAPACITY;
					text_len -= n;
				end
			end
			ACT_READ: begin
				if (p >= text_len) begin
					r.status = ST_RANGE;
				end else begin
					phys = (p < gap_lo) ? p : gap_hi + (p - gap_lo);
					if (phys < CAPACITY)
						r.char_out = text_mem[phys];
				end
			end
			default: r.status = ST_RANGE;
		endcase
		r.current_length = FIELD_W'(text_len);
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at word %0d: %s got %0d expected %0d", word_count, what, got, want);
		error_count++;
	endtask

	// Start stays high after an accept until the next call decides otherwise,
	// so back-to-back words never see start dropped and raised in one step.
	task automatic send_word(logic [1:0] act, int pos, int ch, int amt);
		req_t w;
		w.action = act;
		w.position = FIELD_W'(pos);
		w.char_in = 8'(ch);
		w.amount = FIELD_W'(amt);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		req <= w;
		do @(posedge clk); while (busy);
		pending_rsps.push_back(apply_command(w));
	endtask

	task automatic drain_results;
		@(negedge clk);
		start <= 1'b0;
		while (pending_rsps.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Picks a position no larger than hi (0 if hi is not positive), mostly close to the gap.
	function automatic int near_position(int hi);
		int p;
		if (hi <= 0)
			return 0;
		if ($urandom_range(9) < 7) begin
			p = gap_lo + int'($urandom_range(4)) - 2;
			if (p < 0)
				p = 0;
			if (p > hi)
				p = hi;
		end else begin
			p = int'($urandom_range(hi));
		end
		return p;
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (pending_rsps.size() == 0) begin
				report_mismatch("unexpected word, status", int'(rsp.status), -1);
			end else begin
				want = pending_rsps.pop_front();
				if (rsp.status !== want.status)
					report_mismatch("status", int'(rsp.status), int'(want.status));
				if (rsp.char_out !== want.char_out)
					report_mismatch("char_out", int'(rsp.char_out), int'(want.char_out));
				if (rsp.current_length !== want.current_length)
					report_mismatch("current_length", int'(rsp.current_length),
						int'(want.current_length));
			end
			word_count++;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic test_directed;
		sender_idle_pct = 0;
		send_word(ACT_READ, 0, 0, 0);
		send_word(ACT_REMOVE, 0, 0, 0);
		send_word(ACT_INSERT, 1, 8'h11, 0);
		send_word(ACT_INSERT, CAPACITY, 8'h22, 0);
		send_word(ACT_UNKNOWN, 0, 8'h33, 1);
		send_word(ACT_INSERT, 0, 8'h00, MAX_MAX);
		send_word(ACT_INSERT, 1, 8'hFF, 0);
		send_word(ACT_INSERT, 0, 8'h5A, 0);
		send_word(ACT_INSERT, 3, 8'hA5, 0);
		send_word(ACT_INSERT, 2, 8'h3C, 0);
		for (int i = 0; i < 5; i++)
			send_word(ACT_READ, i, 8'hFF, MAX_MAX);
		send_word(ACT_READ, 5, 0, 0);
		send_word(ACT_READ, MAX_MAX, 0, 0);
		// A zero-length remove still drags the gap to its position.
		send_word(ACT_REMOVE, 2, 0, 0);
		send_word(ACT_REMOVE, 1, 0, 1);
		send_word(ACT_REMOVE, 3, 0, MAX_MAX);
		send_word(ACT_REMOVE, 3, 0, 0);
		send_word(ACT_READ, 2, 0, 0);
		send_word(ACT_REMOVE, 0, 8'hFF, CAPACITY);
		send_word(ACT_INSERT, 0, 8'h80, 0);
		drain_results();
	endtask

	task automatic test_fill_full;
		sender_idle_pct = 0;
		while (text_len < CAPACITY)
			send_word(ACT_INSERT, text_len, int'($urandom_range(255)), 0);
		send_word(ACT_INSERT, CAPACITY, 8'h7E, 0);
		send_word(ACT_INSERT, 0, 8'h7E, 0);
		// The range check wins over the full check.
		send_word(ACT_INSERT, CAPACITY + 1, 8'h7E, 0);
		send_word(ACT_READ, 0, 0, 0);
		send_word(ACT_READ, CAPACITY - 1, 0, 0);
		send_word(ACT_READ, CAPACITY, 0, 0);
		send_word(ACT_REMOVE, 0, 0, 1);
		send_word(ACT_INSERT, 0, 8'hC3, 0);
		send_word(ACT_READ, 0, 0, 0);
		send_word(ACT_REMOVE, CAPACITY / 2, 0, 1);
		send_word(ACT_READ, CAPACITY / 2, 0, 0);
		send_word(ACT_REMOVE, 0, 0, MAX_MAX);
		drain_results();
	endtask

	task automatic test_random_edits(int n_words, int idle_pct);
		int roll;
		int amt_roll;
		int amt;
		sender_idle_pct = idle_pct;
		for (int i = 0; i < n_words; i++) begin
			roll = int'($urandom_range(99));
			if (roll < 10) begin
				send_word(2'($urandom_range(3)), int'($urandom_range(MAX_MAX)),
					int'($urandom_range(255)), int'($urandom_range(MAX_MAX)));
			end else if (roll < 50 && text_len <= 200) begin
				send_word(ACT_INSERT, near_position(text_len), int'($urandom_range(255)),
					int'($urandom_range(MAX_MAX)));
			end else if (roll < 72 || text_len > 200) begin
				amt_roll = int'($urandom_range(19));
				if (amt_roll < 15)
					amt = int'($urandom_range(4));
				else if (amt_roll < 19)
					amt = int'($urandom_range(text_len));
				else
					amt = int'($urandom_range(MAX_MAX));
				send_word(ACT_REMOVE, near_position(text_len - 1),
					int'($urandom_range(255)), amt);
			end else begin
				send_word(ACT_READ, near_position(text_len - 1), int'($urandom_range(255)),
					int'($urandom_range(MAX_MAX)));
			end
		end
		drain_results();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_fill_full();
		test_random_edits(700, 0);
		test_random_edits(700, 81);
		test_random_edits(600, 7);
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: gap_buffer_text_store_top.f
hw/rtl/gbts_pkg.sv
hw/rtl/gbts_ram.sv
hw/rtl/gbts_dp.sv
hw/rtl/gbts_ctrl.sv
hw/rtl/gap_buffer_text_store_top.sv
tb/tb_top.sv
